@@ sv/aesk_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and byte functions for the tweaked CFB keystream block.
// No dependencies.
package aesk_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned RowCount   = 16;
  localparam int unsigned RowAw      = 4;
  localparam logic [7:0] ByteMax     = 8'hFF;
  localparam logic [7:0] TweakAdd    = 8'd5;
  localparam logic [4:0] MaxCount    = 5'd16;

  // key size codes
  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;

  // register indexes
  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_KEYSIZE = 3'd4;
  localparam logic [2:0] REG_IV_HIGH = 3'd5;
  localparam logic [2:0] REG_IV_LOW  = 3'd6;

  typedef struct packed {
    logic [63:0] text_high;
    logic [63:0] text_low;
    logic [4:0]  valid_bytes;
    logic        restart;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic [4:0]  out_bytes;
  } out_item_t;

  // one round-key row write from the key expander
  typedef struct packed {
    logic              en;
    logic [RowAw-1:0]  addr;
    logic [127:0]      data;
  } rk_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

@@ sv/aesk_key_expand.sv @@
`timescale 1ns / 1ps
// Key schedule sequencer: one 32-bit word per cycle, emits a 128-bit row every 4 words.
// Depends on aesk_pkg.
module aesk_key_expand (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [255:0]         key_i,
  input  logic [1:0]           key_size_i,
  output aesk_pkg::rk_wr_t     wr_o,
  output logic                 busy_o
);
  import aesk_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  idx_q, idx_d;
  logic [2:0]  phase_q, phase_d;   // word index mod nk
  logic [7:0]  rcon_q, rcon_d;
  logic [31:0] win_q [8];          // win_q[0] is the newest word
  logic [31:0] key_words [8];
  logic [3:0]  nk;
  logic [5:0]  total;
  logic [31:0] t_word, back_word, new_word;

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      key_words[n] = key_i[255 - 32*n -: 32];
    end
  end

  always_comb begin
    case (key_size_i)
      KEY_128: begin
        nk = 4'd4; total = 6'd44; back_word = win_q[3];
      end
      KEY_192: begin
        nk = 4'd6; total = 6'd52; back_word = win_q[5];
      end
      default: begin
        nk = 4'd8; total = 6'd60; back_word = win_q[7];
      end
    endcase
  end

  always_comb begin
    t_word = win_q[0];
    if (phase_q == 3'd0) begin
      t_word = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon_q, 24'h0};
    end else if (nk == 4'd8 && phase_q == 3'd4) begin
      t_word = sub_word(win_q[0]);
    end
    if (idx_q < {2'b00, nk}) begin
      new_word = key_words[idx_q[2:0]];
    end else begin
      new_word = back_word ^ t_word;
    end
  end

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    phase_d = phase_q;
    rcon_d  = rcon_q;
    if (start_i) begin
      busy_d  = 1'b1;
      idx_d   = '0;
      phase_d = '0;
      rcon_d  = 8'h01;
    end else if (busy_q) begin
      idx_d   = idx_q + 6'd1;
      phase_d = ({1'b0, phase_q} == nk - 4'd1) ? 3'd0 : phase_q + 3'd1;
      if (phase_q == 3'd0 && idx_q >= {2'b00, nk}) begin
        rcon_d = xtime(rcon_q);
      end
      if (idx_q == total - 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;   // expand the reset key
      idx_q   <= '0;
      phase_q <= '0;
      rcon_q  <= 8'h01;
    end else begin
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
      rcon_q  <= rcon_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !start_i) begin
      win_q[0] <= new_word;
      for (int n = 1; n < 8; n++) begin
        win_q[n] <= win_q[n-1];
      end
    end
  end

  assign wr_o.en   = busy_q && !start_i && (idx_q[1:0] == 2'd3);
  assign wr_o.addr = idx_q[5:2];
  assign wr_o.data = {win_q[2], win_q[1], win_q[0], new_word};
  assign busy_o    = busy_q || start_i;

endmodule

@@ sv/aesk_round.sv @@
`timescale 1ns / 1ps
// One AES round: SubBytes, ShiftRows, MixColumns (skipped on the last round), AddRoundKey.
// Depends on aesk_pkg.
module aesk_round (
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  input  logic         last_i,
  output logic [127:0] state_o
);
  import aesk_pkg::*;

  logic [7:0] sb [16];
  logic [7:0] sr [16];
  logic [7:0] mc [16];
  logic [7:0] a0, a1, a2, a3, all;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      sb[k] = SBOX[state_i[127 - 8*k -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[4*c + r] = sb[4*((c + r) % 4) + r];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0  = sr[4*c];
      a1  = sr[4*c + 1];
      a2  = sr[4*c + 2];
      a3  = sr[4*c + 3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (last_i) begin
        mc[4*c] = a0; mc[4*c+1] = a1; mc[4*c+2] = a2; mc[4*c+3] = a3;
      end else begin
        mc[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        mc[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        mc[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        mc[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int k = 0; k < 16; k++) begin
      state_o[127 - 8*k -: 8] = mc[k] ^ rkey_i[127 - 8*k -: 8];
    end
  end

endmodule

@@ sv/aes_cfb_tweaked_keystream.sv @@
`timescale 1ns / 1ps
// Top level: config registers, round-key memory, round sequencer, tweak and output register.
// Depends on aesk_pkg, aesk_key_expand, aesk_round.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | in_data_i (in_item_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (out_item_t)
//  cfg     | input     | psel/penable/pready   | paddr, pwdata, prdata
//
// After accept an item goes through ST_ARK (initial AddRoundKey), nr rounds in ST_ROUND
// and ST_DONE, which loads the output register; the next item is taken back in ST_IDLE:
// one round per cycle, each round key read from a 16 x 128 memory via a read register.
// A key or key_size write, and reset, start a rebuild of the schedule of 44..60 words
// (one word a cycle); no transaction is accepted meanwhile.
// One item is in flight at a time; a finished result waits in the output register while
// the next item is taken, and only the final step waits on a stalled output.
module aes_cfb_tweaked_keystream (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  aesk_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output aesk_pkg::out_item_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  import aesk_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ARK   = 4'b0010,
    ST_ROUND = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  // config registers
  logic [63:0] key0_q, key1_q, key2_q, key3_q, iv_high_q, iv_low_q;
  logic [1:0]  key_size_q;
  logic        cfg_wr, key_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign key_wr  = cfg_wr && (cfg_idx == REG_KEY0 || cfg_idx == REG_KEY1 ||
                   cfg_idx == REG_KEY2 || cfg_idx == REG_KEY3 || cfg_idx == REG_KEYSIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0;
      key_size_q <= KEY_128;
      iv_high_q <= '0; iv_low_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY0:    key0_q <= pwdata;
        REG_KEY1:    key1_q <= pwdata;
        REG_KEY2:    key2_q <= pwdata;
        REG_KEY3:    key3_q <= pwdata;
        REG_KEYSIZE: key_size_q <= pwdata[1:0];
        REG_IV_HIGH: iv_high_q <= pwdata;
        REG_IV_LOW:  iv_low_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KEY0:    prdata = key0_q;
      REG_KEY1:    prdata = key1_q;
      REG_KEY2:    prdata = key2_q;
      REG_KEY3:    prdata = key3_q;
      REG_KEYSIZE: prdata = {62'h0, key_size_q};
      REG_IV_HIGH: prdata = iv_high_q;
      REG_IV_LOW:  prdata = iv_low_q;
      default:     prdata = '0;
    endcase
  end

  // key schedule
  rk_wr_t rk_wr;
  logic   exp_busy;

  aesk_key_expand u_key_expand (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (key_wr),
    .key_i      ({key0_q, key1_q, key2_q, key3_q}),
    .key_size_i (key_size_q),
    .wr_o       (rk_wr),
    .busy_o     (exp_busy)
  );

  // round-key memory; new items stall during expansion; one in flight is not protected
  logic [127:0]     rk_mem [RowCount];
  logic [127:0]     rk_rdata_q;
  logic [RowAw-1:0] rk_raddr;

  always_ff @(posedge clk_i) begin
    if (rk_wr.en) begin
      rk_mem[rk_wr.addr] <= rk_wr.data;
    end
    rk_rdata_q <= rk_mem[rk_raddr];
  end

  // round sequencer
  state_e       st_q, st_d;
  logic [3:0]   rnd_q, rnd_d, nr;
  logic [127:0] aes_q, aes_d, round_out;
  logic [127:0] chain_q, chain_d;
  logic [127:0] text_q;
  logic [4:0]   count_q;
  logic         in_acc, out_free;
  out_item_t    out_q, out_d;
  logic         out_valid_q, out_valid_d;

  always_comb begin
    case (key_size_q)
      KEY_128: nr = 4'd10;
      KEY_192: nr = 4'd12;
      default: nr = 4'd14;
    endcase
  end

  assign in_stall_o = (st_q != ST_IDLE) || exp_busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  aesk_round u_round (
    .state_i (aes_q),
    .rkey_i  (rk_rdata_q),
    .last_i  (rnd_q == nr),
    .state_o (round_out)
  );

  // tweak and masking
  logic [7:0]   ks [16];
  logic [7:0]   ct [16];
  logic [127:0] ct_flat, mo_flat;
  logic [3:0]   hit_idx;
  logic         hit;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      ks[k] = aes_q[127 - 8*k -: 8];
    end
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = 0; k < 15; k++) begin
      if (ks[k] != ByteMax) begin
        hit     = 1'b1;
        hit_idx = 4'(k);
      end
    end
    if (ks[15] > ByteMax - TweakAdd) begin
      if (hit) begin
        ks[hit_idx] = ks[hit_idx] + 8'd1;
      end
    end else begin
      ks[15] = ks[15] + TweakAdd;
    end
    for (int k = 0; k < 16; k++) begin
      ct[k] = ks[k] ^ text_q[127 - 8*k -: 8];
      ct_flat[127 - 8*k -: 8] = ct[k];
      mo_flat[127 - 8*k -: 8] = (5'(k) < count_q) ? ct[k] : 8'h00;
    end
  end

  always_comb begin
    st_d        = st_q;
    rnd_d       = rnd_q;
    aes_d       = aes_q;
    chain_d     = chain_q;
    rk_raddr    = '0;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          aes_d = in_data_i.restart ? {iv_high_q, iv_low_q} : chain_q;
          st_d  = ST_ARK;
        end
      end
      ST_ARK: begin
        aes_d    = aes_q ^ rk_rdata_q;
        rk_raddr = 4'd1;
        rnd_d    = 4'd1;
        st_d     = ST_ROUND;
      end
      ST_ROUND: begin
        aes_d    = round_out;
        rk_raddr = rnd_q + 4'd1;
        if (rnd_q == nr) begin
          st_d = ST_DONE;
        end else begin
          rnd_d = rnd_q + 4'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          chain_d           = ct_flat;
          out_d.cipher_high = mo_flat[127:64];
          out_d.cipher_low  = mo_flat[63:0];
          out_d.out_bytes   = count_q;
          out_valid_d       = 1'b1;
          st_d              = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      rnd_q       <= '0;
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      rnd_q       <= rnd_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    aes_q <= aes_d;
    out_q <= out_d;
    if (in_acc) begin
      text_q  <= {in_data_i.text_high, in_data_i.text_low};
      count_q <= (in_data_i.valid_bytes > MaxCount) ? MaxCount : in_data_i.valid_bytes;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/tb_aes_cfb_tweaked_keystream.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for aes_cfb_tweaked_keystream: directed and random blocks
// over all key sizes, checked against an in-bench CFB/AES keystream predictor.
// Depends on aesk_pkg and the aes_cfb_tweaked_keystream RTL.
module tb_aes_cfb_tweaked_keystream;
  import aesk_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned LongHold = 400;
  localparam logic [1:0] KEY_256 = 2'd2;
  localparam logic [1:0] KEY_RSVD = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  aes_cfb_tweaked_keystream i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [63:0] key_word [4];
  logic [1:0] key_len;
  logic [63:0] iv_hi, iv_lo;
  logic [63:0] chain_hi, chain_lo;
  logic [31:0] round_keys [60];
  out_item_t cipher_q [$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_reqs = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned key_nk();
    return (key_len == KEY_128) ? 4 : ((key_len == KEY_192) ? 6 : 8);
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic void rebuild_schedule();
    int unsigned nk;
    int unsigned total;
    logic [7:0] rc;
    logic [31:0] t;
    nk = key_nk();
    total = 4 * (nk + 7);
    rc = 8'h01;
    foreach (round_keys[i]) round_keys[i] = '0;
    for (int i = 0; i < nk; i++)
      round_keys[i] = (i % 2 == 0) ? key_word[i / 2][63:32] : key_word[i / 2][31:0];
    for (int i = nk; i < total && i < 60; i++) begin
      t = round_keys[i - 1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_double(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      round_keys[i] = round_keys[i - nk] ^ t;
    end
  endfunction

  function automatic logic [127:0] encrypt_chain(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, mix;
    logic [31:0] w;
    logic [127:0] res;
    int unsigned nr;
    nr = key_nk() + 6;
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
    for (int rnd = 0; rnd <= nr; rnd++) begin
      if (rnd != 0) begin
        for (int i = 0; i < 16; i++) t[i] = SBOX[s[i]];
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++) s[4 * c + i] = t[4 * ((c + i) % 4) + i];
        if (rnd != nr) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
            mix = a0 ^ a1 ^ a2 ^ a3;
            s[4 * c]     = a0 ^ mix ^ gf_double(a0 ^ a1);
            s[4 * c + 1] = a1 ^ mix ^ gf_double(a1 ^ a2);
            s[4 * c + 2] = a2 ^ mix ^ gf_double(a2 ^ a3);
            s[4 * c + 3] = a3 ^ mix ^ gf_double(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++) begin
        w = round_keys[(4 * rnd + c) % 60];
        for (int r = 0; r < 4; r++) s[4 * c + r] ^= w[31 - 8 * r -: 8];
      end
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
    return res;
  endfunction

  // advances the chain and returns the masked ciphertext for one block
  function automatic out_item_t predict_cipher(input in_item_t blk);
    logic [127:0] ks, ct, masked;
    logic [4:0] cnt;
    int idx;
    out_item_t res;
    cnt = (blk.valid_bytes > MaxCount) ? MaxCount : blk.valid_bytes;
    if (blk.restart) begin
      chain_hi = iv_hi;
      chain_lo = iv_lo;
    end
    ks = encrypt_chain({chain_hi, chain_lo});
    if ({1'b0, ks[7:0]} + 9'(TweakAdd) > 9'(ByteMax)) begin
      // overflow: bump the highest non-saturated byte below byte 15
      idx = 14;
      while (idx >= 0 && ks[127 - 8 * idx -: 8] == ByteMax) idx--;
      if (idx >= 0) ks[127 - 8 * idx -: 8] = ks[127 - 8 * idx -: 8] + 8'd1;
    end else begin
      ks[7:0] = ks[7:0] + TweakAdd;
    end
    ct = ks ^ {blk.text_high, blk.text_low};
    masked = '0;
    for (int i = 0; i < 16; i++)
      if (i < cnt) masked[127 - 8 * i -: 8] = ct[127 - 8 * i -: 8];
    {chain_hi, chain_lo} = ct;
    res.cipher_high = masked[127:64];
    res.cipher_low = masked[63:0];
    res.out_bytes = cnt;
    return res;
  endfunction

  // result side: random stall, long hold-off on request, and the compare
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;
  always @(posedge clk_i) begin
    out_item_t exp_c;
    if (out_valid_o && !out_stall_i) begin
      if (cipher_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, out_data_o);
      end else begin
        exp_c = cipher_q.pop_front();
        if (out_data_o.cipher_high !== exp_c.cipher_high) begin
          errors++;
          $display("%0t cipher_high exp %h got %h", $time, exp_c.cipher_high,
                   out_data_o.cipher_high);
        end
        if (out_data_o.cipher_low !== exp_c.cipher_low) begin
          errors++;
          $display("%0t cipher_low exp %h got %h", $time, exp_c.cipher_low,
                   out_data_o.cipher_low);
        end
        if (out_data_o.out_bytes !== exp_c.out_bytes) begin
          errors++;
          $display("%0t out_bytes exp %0d got %0d", $time, exp_c.out_bytes,
                   out_data_o.out_bytes);
        end
      end
    end
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = LongHold;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < rx_idle_pct);
  end

  task automatic send_block(input in_item_t blk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= blk;
    do @(posedge clk_i); while (in_stall_o);
    cipher_q.push_back(predict_cipher(blk));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_word[idx] = val;
      REG_KEYSIZE: key_len = val[1:0];
      REG_IV_HIGH: iv_hi = val;
      REG_IV_LOW: iv_lo = val;
      default: ;
    endcase
    if (idx <= REG_KEYSIZE) rebuild_schedule();
  endtask

  task automatic load_key(input logic [1:0] len, input logic [63:0] k0, k1, k2, k3);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
    write_reg(REG_KEYSIZE, {62'd0, len});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t rand_block();
    in_item_t b;
    int unsigned pick;
    b.text_high = rand64();
    b.text_low = rand64();
    b.restart = ($urandom_range(9) == 0);
    pick = $urandom_range(19);
    if (pick < 14) b.valid_bytes = MaxCount;
    else if (pick < 18) b.valid_bytes = 5'($urandom_range(15, 1));
    else if (pick == 18) b.valid_bytes = 5'd0;
    else b.valid_bytes = 5'($urandom_range(31, 17));
    return b;
  endfunction

  function automatic in_item_t make_block(input logic [63:0] hi, lo, input logic [4:0] n,
                                          input logic rs);
    in_item_t b;
    b.text_high = hi; b.text_low = lo; b.valid_bytes = n; b.restart = rs;
    return b;
  endfunction

  // zero key straight out of reset, field extremes, odd counts, restart
  task automatic test_field_extremes();
    send_block(make_block('0, '0, MaxCount, 1'b0));
    send_block(make_block('1, '1, MaxCount, 1'b0));
    send_block(make_block('1, '1, 5'd1, 1'b0));
    send_block(make_block('1, '1, 5'd15, 1'b0));
    send_block(make_block('1, '1, 5'd0, 1'b0));
    send_block(make_block('1, '1, 5'd17, 1'b0));
    send_block(make_block('1, '1, 5'd31, 1'b0));
    wait_idle();
    write_reg(REG_IV_HIGH, '1);
    write_reg(REG_IV_LOW, '1);
    send_block(make_block(64'h0123456789abcdef, 64'hfedcba9876543210, MaxCount, 1'b1));
    send_block(make_block('0, '0, MaxCount, 1'b0));
    send_block(make_block('0, '0, 5'd8, 1'b1));
    wait_idle();
  endtask

  // every key size including the reserved code, with extreme or part-extreme keys but for the reserved code
  task automatic test_key_sizes();
    load_key(KEY_128, '1, '1, '0, '0);
    send_block(make_block(rand64(), rand64(), MaxCount, 1'b1));
    send_block(make_block(rand64(), rand64(), MaxCount, 1'b0));
    wait_idle();
    load_key(KEY_192, rand64(), rand64(), '1, '0);
    send_block(make_block(rand64(), rand64(), MaxCount, 1'b1));
    send_block(make_block(rand64(), rand64(), 5'd3, 1'b0));
    wait_idle();
    load_key(KEY_256, '1, '1, '1, '1);
    send_block(make_block(rand64(), rand64(), MaxCount, 1'b1));
    send_block(make_block(rand64(), rand64(), MaxCount, 1'b0));
    wait_idle();
    load_key(KEY_RSVD, rand64(), rand64(), rand64(), rand64());
    send_block(make_block(rand64(), rand64(), MaxCount, 1'b1));
    send_block(make_block(rand64(), rand64(), 5'd12, 1'b0));
    wait_idle();
  endtask

  task automatic test_random_traffic(input logic [1:0] len, input int unsigned tx_pct,
                                     input int unsigned rx_pct, input int unsigned count);
    load_key(len, rand64(), rand64(), rand64(), rand64());
    write_reg(REG_IV_HIGH, rand64());
    write_reg(REG_IV_LOW, rand64());
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    send_block(make_block(rand64(), rand64(), MaxCount, 1'b1));
    for (int i = 0; i < count; i++) send_block(rand_block());
    wait_idle();
  endtask

  // output held off while blocks keep coming, so the input must stall
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_reqs++;
    for (int i = 0; i < 20; i++) send_block(rand_block());
    wait_idle();
  endtask

  initial begin
    key_word = '{default: '0};
    key_len = KEY_128;
    iv_hi = '0; iv_lo = '0;
    chain_hi = '0; chain_lo = '0;
    rebuild_schedule();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_key_sizes();
    test_random_traffic(KEY_128, 38, 75, 250);
    test_random_traffic(KEY_192, 75, 38, 250);
    test_random_traffic(KEY_256, 0, 0, 250);
    test_output_backpressure();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/aesk_pkg.sv
sv/aesk_key_expand.sv
sv/aesk_round.sv
sv/aes_cfb_tweaked_keystream.sv
tb/tb_aes_cfb_tweaked_keystream.sv
